/* hw/rtl/rmst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the range minimum segment tree
// Holds the item function codes, the sequencer states, the neutral value
// and the signed minimum used when folding node values.
// ----------------------------------------------------------------------------
package rmst_pkg;

	// Width of one tree node.
	localparam int unsigned NODE_W = 32;

	// Value of an empty range and of every node after reset.
	localparam logic [NODE_W-1:0] NEUTRAL = 32'h7FFF_FFFF;

	// Item function codes.
	localparam logic FUNC_SET   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_QLEFT,
		ST_QRIGHT,
		ST_QFIN
	} state_t;

	// Minimum of two node words compared as signed values.
	function automatic logic [NODE_W-1:0] smin(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		return ($signed(b) < $signed(a)) ? b : a;
	endfunction

endpackage

/* hw/rtl/rmst_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rmst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/range_min_segment_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree: range minimum segment tree over LEAVES leaves
// Keeps a binary tree of signed 32-bit minima in one synchronous RAM and
// serves set items (write a leaf, refresh its ancestors) and query items
// (minimum over a half-open leaf range).
// ----------------------------------------------------------------------------
// Usage:
// - Input channel item_valid / item_stall carries func, position, value,
//   range_low and range_high. An item is taken when item_valid is high and
//   item_stall is low; item_stall is high whenever the sequencer is busy.
// - Output channel result_valid / result_stall carries minimum, one item
//   per query and none per set.
// - The RAM has one read and one write port with registered read. A set
//   refreshes one node per tree level, with the sibling read of the next
//   level overlapped with the parent write.
// - A query walks both range borders up the tree, one level per ST_QLEFT
//   and ST_QRIGHT pair, before its result is registered; an empty range
//   goes from ST_QLEFT straight to ST_QFIN.
// - After reset the block writes 2147483647 to every RAM word; item_stall
//   stays high during that pass.
// - While result_stall holds a result, the next item may still be taken;
//   a query that finishes before the result is taken waits in its last
//   state until the output register frees.
// ----------------------------------------------------------------------------
module range_min_segment_tree
	import rmst_pkg::*;
#(
	parameter int unsigned LEAVES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               func,
	input  logic        [9:0]  position,
	input  logic signed [31:0] value,
	input  logic        [9:0]  range_low,
	input  logic        [10:0] range_high,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] minimum
);

	// Leaf index bits, RAM address bits, border counter bits, compare bits.
	localparam int unsigned LW = $clog2(LEAVES);
	localparam int unsigned AW = LW + 1;
	localparam int unsigned HW = LW + 2;
	localparam int unsigned CW = (LW + 1 > 11) ? LW + 1 : 11;

	state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     v_q, v_d;
	logic [NODE_W-1:0] cur_q, cur_d;
	logic [HW-1:0]     l_q, l_d, r_q, r_d;
	logic [NODE_W-1:0] res_q;
	logic              qrd_q, qrd;
	logic              out_load;
	logic [NODE_W-1:0] minimum_q;
	logic              result_valid_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [NODE_W-1:0] ram_wdata, ram_rdata;

	logic              accept;
	logic [CW-1:0]     pos_ext, lo_ext, hi_ext, hi_clamp;
	logic              set_ok, q_empty;
	logic [AW-1:0]     leaf_addr, parent;
	logic [NODE_W-1:0] upd_min;
	logic [HW-1:0]     r_dec;

	// Decode the incoming item.
	assign accept    = item_valid && !item_stall;
	assign pos_ext   = CW'(position);
	assign lo_ext    = CW'(range_low);
	assign hi_ext    = CW'(range_high);
	assign hi_clamp  = (hi_ext > CW'(LEAVES)) ? CW'(LEAVES) : hi_ext;
	assign set_ok    = pos_ext < CW'(LEAVES);
	assign q_empty   = lo_ext >= hi_clamp;
	assign leaf_addr = AW'(LEAVES) + AW'(pos_ext[LW-1:0]);
	assign parent    = v_q >> 1;
	assign upd_min   = smin(cur_q, ram_rdata);
	assign r_dec     = r_q - HW'(r_q[0]);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_QUERY) state_d = ST_QLEFT;
					else if (set_ok) state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (parent == AW'(1)) state_d = ST_IDLE;
			end
			ST_QLEFT: begin
				state_d = (l_q >= r_q) ? ST_QFIN : ST_QRIGHT;
			end
			ST_QRIGHT: begin
				state_d = ST_QLEFT;
			end
			ST_QFIN: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// RAM port control and working register updates.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = NEUTRAL;
		ram_raddr = '0;
		qrd       = 1'b0;
		out_load  = 1'b0;
		v_d       = v_q;
		cur_d     = cur_q;
		l_d       = l_q;
		r_d       = r_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				// A set writes its leaf and fetches the sibling at once.
				ram_raddr = leaf_addr ^ AW'(1);
				v_d       = leaf_addr;
				cur_d     = value;
				if (accept && func == FUNC_SET && set_ok) begin
					ram_we    = 1'b1;
					ram_waddr = leaf_addr;
					ram_wdata = value;
				end
				if (q_empty) begin
					l_d = '0;
					r_d = '0;
				end else begin
					l_d = HW'(lo_ext) + HW'(LEAVES);
					r_d = HW'(hi_clamp) + HW'(LEAVES);
				end
			end
			ST_UPDATE: begin
				// Parent takes the minimum of both children; fetch its sibling.
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = upd_min;
				ram_raddr = parent ^ AW'(1);
				v_d       = parent;
				cur_d     = upd_min;
			end
			ST_QLEFT: begin
				// Left border on a right child: take the node and step right.
				ram_raddr = AW'(l_q);
				if (l_q < r_q && l_q[0]) begin
					qrd = 1'b1;
					l_d = l_q + HW'(1);
				end
			end
			ST_QRIGHT: begin
				// Right border on a right child: step left and take the node.
				ram_raddr = AW'(r_dec);
				qrd       = r_q[0];
				l_d       = l_q >> 1;
				r_d       = r_dec >> 1;
			end
			ST_QFIN: begin
				out_load = !result_valid_q || !result_stall;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			qrd_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			qrd_q          <= qrd;
			result_valid_q <= out_load || (result_valid_q && result_stall);
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		v_q   <= v_d;
		cur_q <= cur_d;
		l_q   <= l_d;
		r_q   <= r_d;
		if (accept) begin
			res_q <= NEUTRAL;
		end else if (qrd_q) begin
			res_q <= smin(res_q, ram_rdata);
		end
		if (out_load) minimum_q <= res_q;
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign minimum      = minimum_q;

	// Tree node store, addressed by one-based heap index.
	rmst_ram #(
		.WIDTH(NODE_W),
		.DEPTH(2 * LEAVES)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	// The update never reads the word it writes in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (ram_waddr != ram_raddr))
		else $error("update reads the node it writes");

	// The update walk stops below the root.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (v_q > AW'(1)))
		else $error("update walked past the root");

	// The left border never passes the right border.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QLEFT || state_q == ST_QRIGHT) |-> (l_q <= r_q))
		else $error("query borders crossed");

	// A new result only comes out of the final query state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_QFIN))
		else $error("result without a finished query");
`endif

endmodule
